FILE: design/msd_pkg.sv
// shared types and constants for the mean squared displacement accumulator
// no dependencies; imported by every module of the block but msd_ram
package msd_pkg;

    localparam int ATOMS_MAX  = 4096;
    localparam int COORD_BITS = 24;

    localparam int ID_W   = 13;
    localparam int SLOT_W = (ATOMS_MAX > 1) ? $clog2(ATOMS_MAX) : 1;
    localparam int REF_W  = 3 * COORD_BITS;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MAG_W  = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int ITEM_W = SQ_W + 2;
    localparam int SUM_W  = 63;
    localparam int ACC_W  = ((ITEM_W > SUM_W) ? ITEM_W : SUM_W) + 1;

    localparam logic [SUM_W-1:0] SUM_CAP = '1;

    typedef enum logic [1:0] {
        ST_SUM    = 2'd0,
        ST_LOADED = 2'd1,
        ST_ID_ERR = 2'd2,
        ST_NO_REF = 2'd3
    } status_t;

    // per-word tag that rides along the pipeline
    typedef struct packed {
        logic    mode;
        logic    last;
        logic    err;
        status_t err_code;
    } item_tag_t;

    typedef struct packed {
        logic halted;
        logic ref_valid;
    } ctrl_flags_t;

endpackage

FILE: design/msd_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module msd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/msd_front.sv
// input word check: id order, reference presence, halt, frame end, ram access
// depends on msd_pkg
module msd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [msd_pkg::ID_W-1:0]      cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [msd_pkg::ID_W-1:0]      atom_id,
    input  logic [msd_pkg::COORD_BITS-1:0] pos_x,
    input  logic [msd_pkg::COORD_BITS-1:0] pos_y,
    input  logic [msd_pkg::COORD_BITS-1:0] pos_z,
    input  logic                          s1_en,
    output logic                          s1_valid,
    output msd_pkg::item_tag_t            s1_tag,
    output logic [msd_pkg::REF_W-1:0]     s1_pos,
    output logic                          mem_we,
    output logic                          mem_re,
    output logic [msd_pkg::SLOT_W-1:0]    mem_addr,
    output logic [msd_pkg::REF_W-1:0]     mem_wdata,
    output msd_pkg::ctrl_flags_t          flags
);
    import msd_pkg::*;

    logic            s1_valid_reg, s1_valid_next;
    item_tag_t       s1_tag_reg, s1_tag_next;
    logic [REF_W-1:0] s1_pos_reg;
    logic            halted_reg, halted_next;
    logic            ref_valid_reg, ref_valid_next;
    logic [ID_W-1:0] next_id_reg, next_id_next;
    logic [ID_W-1:0] atom_count_reg, atom_count_next;

    logic accept, live, no_ref, id_ok, good, last;

    assign in_ready = s1_en;
    assign accept   = in_valid & s1_en;
    assign live     = accept & ~halted_reg;
    assign no_ref   = mode & ~ref_valid_reg;
    assign id_ok    = ({1'b0, atom_id} == ({1'b0, next_id_reg} + 1'b1))
                      && (32'(atom_id) <= ATOMS_MAX);
    assign good     = live & ~no_ref & id_ok;
    assign last     = atom_id >= atom_count_reg;

    assign mem_we    = good & ~mode;
    assign mem_re    = good & mode;
    assign mem_addr  = SLOT_W'(atom_id - 1'b1);
    assign mem_wdata = {pos_x, pos_y, pos_z};

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        halted_next     = halted_reg;
        ref_valid_next  = ref_valid_reg;
        next_id_next    = next_id_reg;
        atom_count_next = cfg_we ? cfg_wdata : atom_count_reg;

        s1_tag_next.mode     = mode;
        s1_tag_next.last     = last;
        s1_tag_next.err      = ~good;
        s1_tag_next.err_code = no_ref ? ST_NO_REF : ST_ID_ERR;

        if (s1_en)
        begin
            s1_valid_next = live;
        end
        if (live)
        begin
            if (!good)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                next_id_next = last ? '0 : atom_id;
                if (last && !mode)
                begin
                    ref_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            halted_reg     <= 1'b0;
            ref_valid_reg  <= 1'b0;
            next_id_reg    <= '0;
            atom_count_reg <= ID_W'(1);
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            halted_reg     <= halted_next;
            ref_valid_reg  <= ref_valid_next;
            next_id_reg    <= next_id_next;
            atom_count_reg <= atom_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_tag_reg <= s1_tag_next;
            s1_pos_reg <= mem_wdata;
        end
    end

    assign s1_valid        = s1_valid_reg;
    assign s1_tag          = s1_tag_reg;
    assign s1_pos          = s1_pos_reg;
    assign flags.halted    = halted_reg;
    assign flags.ref_valid = ref_valid_reg;

endmodule

FILE: design/msd_accum.sv
// difference, square, per-atom sum and saturating frame accumulation stages
// depends on msd_pkg; takes the reference read data from msd_ram
module msd_accum (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s1_valid,
    input  msd_pkg::item_tag_t        s1_tag,
    input  logic [msd_pkg::REF_W-1:0] s1_pos,
    input  logic [msd_pkg::REF_W-1:0] ref_data,
    output logic                      s1_en,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                status,
    output logic [msd_pkg::SUM_W-1:0] displacement_sum
);
    import msd_pkg::*;

    logic                     v2_reg, v3_reg, v4_reg;
    item_tag_t                tag2_reg, tag3_reg, tag4_reg;
    logic signed [DIFF_W-1:0] d2_reg  [3];
    logic signed [DIFF_W-1:0] d2_next [3];
    logic [SQ_W-1:0]          sq3_reg  [3];
    logic [SQ_W-1:0]          sq3_next [3];
    logic [ITEM_W-1:0]        item4_reg, item4_next;
    logic [SUM_W-1:0]         running_sum_reg, running_sum_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic [SUM_W-1:0]         sum_out_reg, sum_out_next;

    logic             en2, en3, en4, move4, emit4, out_free;
    logic [ACC_W-1:0] acc_wide;
    logic [SUM_W-1:0] acc_sat;

    // elastic stall chain: a stage loads when empty or when it drains
    assign out_free = ~out_valid_reg | out_ready;
    assign emit4    = tag4_reg.last | tag4_reg.err;
    assign move4    = v4_reg & (~emit4 | out_free);
    assign en4      = ~v4_reg | move4;
    assign en3      = ~v3_reg | en4;
    assign en2      = ~v2_reg | en3;
    assign s1_en    = ~s1_valid | en2;

    always_comb
    begin
        logic signed [COORD_BITS-1:0] p, r;
        for (int k = 0; k < 3; k++)
        begin
            p = s1_pos[k*COORD_BITS +: COORD_BITS];
            r = ref_data[k*COORD_BITS +: COORD_BITS];
            d2_next[k] = DIFF_W'(p) - DIFF_W'(r);
        end
    end

    always_comb
    begin
        logic [MAG_W-1:0]   mag;
        logic [2*MAG_W-1:0] prod;
        for (int k = 0; k < 3; k++)
        begin
            mag = d2_reg[k][DIFF_W-1] ? MAG_W'(-d2_reg[k]) : MAG_W'(d2_reg[k]);
            prod = mag * mag;
            sq3_next[k] = SQ_W'(prod);
        end
    end

    assign item4_next = ITEM_W'(sq3_reg[0]) + ITEM_W'(sq3_reg[1]) + ITEM_W'(sq3_reg[2]);

    assign acc_wide = ACC_W'(running_sum_reg) + ACC_W'(item4_reg);
    assign acc_sat  = (acc_wide > ACC_W'(SUM_CAP)) ? SUM_CAP : acc_wide[SUM_W-1:0];

    always_comb
    begin
        running_sum_next = running_sum_reg;
        status_next      = status_reg;
        sum_out_next     = sum_out_reg;
        out_valid_next   = out_valid_reg & ~out_ready;

        // the output word only changes when a frame end or an error leaves
        if (move4)
        begin
            if (tag4_reg.err)
            begin
                status_next  = tag4_reg.err_code;
                sum_out_next = '0;
            end
            else if (tag4_reg.mode)
            begin
                running_sum_next = tag4_reg.last ? '0 : acc_sat;
                if (tag4_reg.last)
                begin
                    status_next  = ST_SUM;
                    sum_out_next = acc_sat;
                end
            end
            else
            begin
                if (tag4_reg.last)
                begin
                    running_sum_next = '0;
                    status_next      = ST_LOADED;
                    sum_out_next     = '0;
                end
            end
            if (emit4)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            running_sum_reg <= '0;
        end
        else
        begin
            if (en2)
            begin
                v2_reg <= s1_valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            out_valid_reg   <= out_valid_next;
            running_sum_reg <= running_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            tag2_reg <= s1_tag;
            d2_reg   <= d2_next;
        end
        if (en3)
        begin
            tag3_reg <= tag2_reg;
            sq3_reg  <= sq3_next;
        end
        if (en4)
        begin
            tag4_reg  <= tag3_reg;
            item4_reg <= item4_next;
        end
        status_reg  <= status_next;
        sum_out_reg <= sum_out_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign displacement_sum = sum_out_reg;

endmodule

FILE: design/mean_squared_displacement_accumulator.sv
// top level of the mean squared displacement accumulator
// depends on msd_pkg, msd_front, msd_ram and msd_accum
//
// usage:
//   input channel (in_valid/in_ready) carries one atom record per word: mode,
//   atom_id and the signed Q12.12 position pos_x/pos_y/pos_z. mode 0 stores the
//   reference position of the atom, mode 1 adds its squared distance to the
//   reference into the frame sum. ids must count 1,2,3,... inside a frame and a
//   frame ends at the atom whose id reaches atom_count (cfg_we/cfg_wdata).
//   output channel (out_valid/out_ready) carries one word per frame end or
//   error: status plus displacement_sum (Q.24, saturating at 2^63-1).
//   throughput: one word per clock while the output is not stalled; the reference
//   ram takes one write or one read per word. the result passes the ram read,
//   difference, square and sum registers before it shows on out_valid.
//   an id order error or a measure without a loaded reference halts the
//   block: later words are accepted and dropped until reset.
//   reset clears control state only; reference entries are undefined until
//   loaded. when the receiver stalls, the output register holds its word and
//   the pipeline keeps filling its bubbles before in_ready drops.
//   a load to an atom followed by a measure of it in the next word needs no
//   bypass: the ram write lands before the following read.
module mean_squared_displacement_accumulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [msd_pkg::ID_W-1:0]       cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [msd_pkg::ID_W-1:0]       atom_id,
    input  logic [msd_pkg::COORD_BITS-1:0] pos_x,
    input  logic [msd_pkg::COORD_BITS-1:0] pos_y,
    input  logic [msd_pkg::COORD_BITS-1:0] pos_z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [msd_pkg::SUM_W-1:0]      displacement_sum
);
    import msd_pkg::*;

    // stage one handoff between the front end and the arithmetic pipeline
    logic             s1_en;
    logic             s1_valid;
    item_tag_t        s1_tag;
    logic [REF_W-1:0] s1_pos;

    // reference ram access, issued in the accepting cycle
    logic              mem_we;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_addr;
    logic [REF_W-1:0]  mem_wdata;
    logic [REF_W-1:0]  ref_data;

    ctrl_flags_t flags;

    msd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .atom_id   (atom_id),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .s1_en     (s1_en),
        .s1_valid  (s1_valid),
        .s1_tag    (s1_tag),
        .s1_pos    (s1_pos),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .flags     (flags)
    );

    // reference positions, x/y/z packed in one 72 bit entry per atom
    msd_ram #(
        .WIDTH (REF_W),
        .DEPTH (ATOMS_MAX)
    ) u_ref_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (ref_data)
    );

    msd_accum u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .s1_valid         (s1_valid),
        .s1_tag           (s1_tag),
        .s1_pos           (s1_pos),
        .ref_data         (ref_data),
        .s1_en            (s1_en),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .displacement_sum (displacement_sum)
    );

    // halt is left only through reset
    assert property (@(posedge clk) disable iff (!rst_n)
        flags.halted |=> flags.halted)
        else $error("halt flag cleared without reset");

    // a loaded reference never goes away
    assert property (@(posedge clk) disable iff (!rst_n)
        flags.ref_valid |=> flags.ref_valid)
        else $error("reference valid flag dropped");

    // only a frame sum word carries a nonzero sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_SUM) |-> (displacement_sum == '0))
        else $error("nonzero sum on a status word");

    // the ram is never written and read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("reference ram written and read together");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for mean_squared_displacement_accumulator: random atom records
// checked against an in-bench frame sum predictor; depends on msd_pkg and the rtl
module tb_top;
    import msd_pkg::*;

    typedef struct {
        logic                  mode;
        logic [ID_W-1:0]       atom_id;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } atom_rec_t;

    typedef struct {
        status_t          st;
        logic [SUM_W-1:0] sum;
    } frame_result_t;

    localparam logic [63:0] SUM_LIMIT = {1'b0, SUM_CAP};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [ID_W-1:0]       cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  mode = 1'b0;
    logic [ID_W-1:0]       atom_id = '0;
    logic [COORD_BITS-1:0] pos_x = '0;
    logic [COORD_BITS-1:0] pos_y = '0;
    logic [COORD_BITS-1:0] pos_z = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic [SUM_W-1:0]      displacement_sum;

    mean_squared_displacement_accumulator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .atom_id          (atom_id),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .displacement_sum (displacement_sum)
    );

    always #5 clk = ~clk;

    // records waiting for the driver, results waiting for the monitor
    atom_rec_t     atoms_pending[$];
    frame_result_t frame_results_due[$];

    // predictor copy of the block state
    logic [COORD_BITS-1:0] ref_x[ATOMS_MAX];
    logic [COORD_BITS-1:0] ref_y[ATOMS_MAX];
    logic [COORD_BITS-1:0] ref_z[ATOMS_MAX];
    logic [ID_W-1:0]       next_id = '0;
    logic [63:0]           frame_acc = '0;
    logic                  ref_ready = 1'b0;
    logic                  blk_halted = 1'b0;
    int                    frame_len = 1;

    // stimulus side bookkeeping: which reference slots hold a loaded position
    bit gen_loaded[ATOMS_MAX];
    bit gen_ref_valid = 1'b0;
    int gen_count = 1;

    // driver / monitor state
    atom_rec_t     cur_atom;
    frame_result_t want;
    int            gap_left = 0;
    int            stall_left = 0;
    bit            quiet = 1'b0;
    int            mismatches = 0;
    int            records_taken = 0;
    int            sums_seen = 0;
    int            loads_seen = 0;
    int            halts_seen = 0;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        if (a >= SUM_LIMIT || b > SUM_LIMIT - a)
            return SUM_LIMIT;
        return a + b;
    endfunction

    function automatic logic [63:0] dist_sq(logic [COORD_BITS-1:0] a,
                                            logic [COORD_BITS-1:0] b);
        longint d;
        d = longint'(signed'(a)) - longint'(signed'(b));
        if (d < 0)
            d = -d;
        return d * d;
    endfunction

    // advances the predicted state by one accepted record and queues its result
    function automatic void predict_record(atom_rec_t r);
        frame_result_t res;
        int            slot;
        res.sum = '0;
        if (blk_halted)
            return;
        // measure before any load frame has finished
        if (r.mode && !ref_ready)
        begin
            blk_halted = 1'b1;
            res.st = ST_NO_REF;
            frame_results_due.push_back(res);
            return;
        end
        // ids must run 1,2,3,... and stay within the reference store
        if (int'(r.atom_id) != int'(next_id) + 1 || int'(r.atom_id) > ATOMS_MAX)
        begin
            blk_halted = 1'b1;
            res.st = ST_ID_ERR;
            frame_results_due.push_back(res);
            return;
        end
        slot = int'(r.atom_id) - 1;
        if (!r.mode)
        begin
            ref_x[slot] = r.x;
            ref_y[slot] = r.y;
            ref_z[slot] = r.z;
        end
        else
        begin
            frame_acc = sat_add(frame_acc, dist_sq(r.x, ref_x[slot]));
            frame_acc = sat_add(frame_acc, dist_sq(r.y, ref_y[slot]));
            frame_acc = sat_add(frame_acc, dist_sq(r.z, ref_z[slot]));
        end
        next_id = r.atom_id;
        if (int'(r.atom_id) < frame_len)
            return;
        // last atom: the frame's mode comes from this record alone
        if (!r.mode)
        begin
            ref_ready = 1'b1;
            res.st = ST_LOADED;
        end
        else
        begin
            res.st = ST_SUM;
            res.sum = frame_acc[SUM_W-1:0];
        end
        frame_results_due.push_back(res);
        next_id = '0;
        frame_acc = '0;
    endfunction

    // driver: one record per word, random gap drawn per record
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_record(cur_atom);
                records_taken++;
            end
            // a word that is still waiting keeps valid and payload untouched
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (atoms_pending.size() != 0)
                begin
                    cur_atom = atoms_pending.pop_front();
                    mode     <= cur_atom.mode;
                    atom_id  <= cur_atom.atom_id;
                    pos_x    <= cur_atom.x;
                    pos_y    <= cur_atom.y;
                    pos_z    <= cur_atom.z;
                    in_valid <= 1'b1;
                    gap_left = quiet ? 0 : $urandom_range(0, 9);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each result word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_results_due.size() == 0)
                begin
                    $error("unexpected word: status %0d displacement_sum %0d",
                           status, displacement_sum);
                    mismatches++;
                end
                else
                begin
                    want = frame_results_due.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, actual %0d", want.st, status);
                        mismatches++;
                    end
                    if (displacement_sum !== want.sum)
                    begin
                        $error("displacement_sum: expected %0d, actual %0d",
                               want.sum, displacement_sum);
                        mismatches++;
                    end
                    case (want.st)
                        ST_SUM:    sums_seen++;
                        ST_LOADED: loads_seen++;
                        default:   halts_seen++;
                    endcase
                end
                stall_left = quiet ? 0 : $urandom_range(0, 9);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic bit bench_busy();
        return atoms_pending.size() != 0 || in_valid || frame_results_due.size() != 0;
    endfunction

    task automatic wait_drained();
        while (bench_busy())
            @(negedge clk);
    endtask

    // only done with the block idle and between frames
    task automatic write_atom_count(int n);
        wait_drained();
        // a mid-frame record leaves no result, so let the pipeline empty too
        repeat (8) @(negedge clk);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 13'(n);
        @(posedge clk);
        cfg_we    <= 1'b0;
        frame_len = n;
        gen_count = n;
        @(negedge clk);
    endtask

    task automatic push_atom(logic m, int id, logic [COORD_BITS-1:0] x,
                             logic [COORD_BITS-1:0] y, logic [COORD_BITS-1:0] z);
        atom_rec_t r;
        r.mode    = m;
        r.atom_id = 13'(id);
        r.x       = x;
        r.y       = y;
        r.z       = z;
        if (!m && id >= 1 && id <= ATOMS_MAX)
            gen_loaded[id-1] = 1'b1;
        if (!m && id >= gen_count)
            gen_ref_valid = 1'b1;
        atoms_pending.push_back(r);
    endtask

    // coordinate styles: 0 full range, 1 corners of the range, 2 near the origin
    function automatic logic [COORD_BITS-1:0] pick_coord(int style);
        case (style)
            1:
                case ($urandom_range(0, 2))
                    0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
                    1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
                    default: return '0;
                endcase
            2:       return COORD_BITS'($urandom_range(0, 8191) - 4096);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // a well-formed frame; measure words on unloaded slots become loads
    task automatic push_frame(bit measure, int mix_pct, int style);
        logic m;
        for (int k = 1; k <= gen_count; k++)
        begin
            m = measure;
            if ($urandom_range(0, 99) < mix_pct)
                m = ~m;
            if (m && (!gen_ref_valid || !gen_loaded[k-1]))
                m = 1'b0;
            push_atom(m, k, pick_coord(style), pick_coord(style), pick_coord(style));
        end
    endtask

    localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    initial
    begin
        int n;
        int r;
        int random_items;
        int good;
        int bad;
        int waited;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-atom frames at the reset frame length
        push_atom(1'b0, 1, C_MIN, C_MIN, C_MIN);
        push_atom(1'b1, 1, C_MAX, C_MAX, C_MAX);     // largest per-atom distance
        push_atom(1'b1, 1, C_MIN, C_MAX, '0);
        push_atom(1'b0, 1, '0, '0, '0);
        push_atom(1'b1, 1, 24'd1, '1, '0);

        // three-atom frames: mixed modes, and a frame that ends in a load
        write_atom_count(3);
        push_frame(1'b0, 0, 0);
        push_atom(1'b1, 1, pick_coord(0), pick_coord(0), pick_coord(0));
        push_atom(1'b0, 2, C_MAX, C_MIN, C_MAX);
        push_atom(1'b1, 3, pick_coord(1), pick_coord(1), pick_coord(1));
        push_atom(1'b1, 1, pick_coord(0), pick_coord(0), pick_coord(0));
        push_atom(1'b1, 2, pick_coord(0), pick_coord(0), pick_coord(0));
        push_atom(1'b0, 3, pick_coord(2), pick_coord(2), pick_coord(2));   // sum dropped

        // random phases, mostly short frames
        random_items = 0;
        while (random_items < 340)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                n = $urandom_range(1, 4);
            else if (r < 9)
                n = $urandom_range(5, 16);
            else
                n = $urandom_range(17, 64);
            write_atom_count(n);
            quiet = ($urandom_range(0, 4) == 0);
            for (int f = $urandom_range(2, 8); f > 0 && random_items < 340; f--)
            begin
                push_frame($urandom_range(0, 3) != 0,
                           ($urandom_range(0, 2) == 0) ? 30 : 0,
                           $urandom_range(0, 2));
                random_items += n;
                // sender holds off until the block has caught up
                if ($urandom_range(0, 7) == 0)
                    wait_drained();
            end
        end
        quiet = 1'b0;

        // id order error, partway into a frame, then words that must be dropped
        wait_drained();
        good = $urandom_range(0, gen_count - 1);
        for (int k = 1; k <= good; k++)
            push_atom(1'b1, k, pick_coord(0), pick_coord(0), pick_coord(0));
        bad = $urandom_range(0, 8191);
        if (bad == good + 1)
            bad = 0;
        push_atom(1'($urandom_range(0, 1)), bad,
                  pick_coord(0), pick_coord(0), pick_coord(0));
        repeat (6)
            push_atom(1'($urandom_range(0, 1)), $urandom_range(0, 8191),
                      pick_coord(0), pick_coord(0), pick_coord(0));

        // drain with a bound, then give stray words a chance to show
        waited = 0;
        while (bench_busy() && waited < 4000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);
        if (frame_results_due.size() != 0)
        begin
            $error("%0d expected words never arrived", frame_results_due.size());
            mismatches += frame_results_due.size();
        end

        $display("covered %0d records over frame lengths 1 to 64, mixed and load-ended frames",
                 records_taken);
        $display("checked %0d frame sums, %0d reference loads, %0d halting errors",
                 sums_seen, loads_seen, halts_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
design/msd_pkg.sv
design/msd_ram.sv
design/msd_front.sv
design/msd_accum.sv
design/mean_squared_displacement_accumulator.sv
sim/tb_top.sv
